@@ sv/kmd_pkg.sv @@
`default_nettype none

package kmd_pkg;

  // Matrix geometry.
  localparam int unsigned NUM_COLUMNS = 9;
  localparam int unsigned NUM_ROWS    = 5;
  localparam int unsigned ROW_STRIDE  = 5;
  localparam int unsigned KEY_BITS    = 45;

  // One lane per column that fits inside the key field.
  localparam int unsigned MAX_COLUMNS = KEY_BITS / ROW_STRIDE;
  localparam int unsigned LANES = (NUM_COLUMNS < MAX_COLUMNS) ? NUM_COLUMNS : MAX_COLUMNS;
  localparam int unsigned USED_BITS = LANES * ROW_STRIDE;

  // Stream widths.
  localparam int unsigned TDATA_W    = ((KEY_BITS + 7) / 8) * 8;
  localparam int unsigned IN_TUSER_W = 2;
  localparam int unsigned OUT_TUSER_W = 2;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned IDLE_W     = LIMIT_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT   = 1'd1;

  localparam logic [THR_W-1:0]   THR_RESET   = 8'd5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd500;

  // Request kind carried in the input tuser.
  typedef enum logic [IN_TUSER_W-1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_RESEND = 2'd1,
    MODE_WAKE   = 2'd2
  } mode_e;

  typedef logic [KEY_BITS-1:0]   keys_t;
  typedef logic [ROW_STRIDE-1:0] col_t;

  // What one column lane found.
  typedef struct packed {
    logic eq_cand;
    logic eq_stable;
    logic released;
  } lane_flags_t;

  // One result item.
  typedef struct packed {
    logic  report;
    keys_t keys;
    logic  asleep;
  } result_t;

  // Rows that exist within one column slice.
  function automatic col_t row_mask();
    col_t m;
    m = '0;
    for (int r = 0; r < int'(ROW_STRIDE); r++) begin
      if (r < int'(NUM_ROWS)) begin
        m[r] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ sv/kmd_lane.sv @@
`default_nettype none

module kmd_lane (
  input  kmd_pkg::col_t        sample_i,
  input  kmd_pkg::col_t        cand_i,
  input  kmd_pkg::col_t        stable_i,
  output kmd_pkg::col_t        sample_o,
  output kmd_pkg::lane_flags_t flags_o
);
  import kmd_pkg::*;

  localparam col_t RowMask = row_mask();

  col_t masked;

  // Drop rows that the matrix does not have, then compare this column.
  assign masked   = sample_i & RowMask;
  assign sample_o = masked;

  assign flags_o.eq_cand   = (masked == cand_i);
  assign flags_o.eq_stable = (masked == stable_i);
  assign flags_o.released  = (masked == '0);

endmodule

`default_nettype wire

@@ sv/kmd_core.sv @@
`default_nettype none

module kmd_core (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        accept_i,
  input  kmd_pkg::mode_e             mode_i,
  input  kmd_pkg::keys_t             sample_i,
  input  kmd_pkg::lane_flags_t       lane_flags_i [kmd_pkg::LANES],
  input  wire [kmd_pkg::THR_W-1:0]   thr_cfg_i,
  input  wire [kmd_pkg::LIMIT_W-1:0] limit_cfg_i,
  output kmd_pkg::keys_t             stable_o,
  output kmd_pkg::keys_t             cand_o,
  output kmd_pkg::result_t           result_o
);
  import kmd_pkg::*;

  keys_t             stable_q, stable_d;
  keys_t             cand_q, cand_d;
  logic              active_q, active_d;
  logic [THR_W-1:0]  count_q, count_d;
  logic [IDLE_W-1:0] idle_q, idle_d;
  logic              sleep_q, sleep_d;

  logic              all_eq_cand, all_eq_stable, all_released;
  logic [THR_W-1:0]  thr;
  logic [THR_W-1:0]  count_inc;
  logic [IDLE_W-1:0] idle_inc;
  logic [IDLE_W-1:0] limit_ext;
  logic              report;

  // Merge the per-column findings into whole-matrix flags.
  always_comb begin
    all_eq_cand   = 1'b1;
    all_eq_stable = 1'b1;
    all_released  = 1'b1;
    for (int c = 0; c < int'(LANES); c++) begin
      all_eq_cand   = all_eq_cand & lane_flags_i[c].eq_cand;
      all_eq_stable = all_eq_stable & lane_flags_i[c].eq_stable;
      all_released  = all_released & lane_flags_i[c].released;
    end
  end

  // A zero threshold behaves as one.
  assign thr       = (thr_cfg_i == '0) ? THR_W'(1) : thr_cfg_i;
  assign count_inc = count_q + THR_W'(1);
  assign idle_inc  = idle_q + IDLE_W'(1);
  assign limit_ext = {1'b0, limit_cfg_i};

  // Next state for one accepted request.
  always_comb begin
    stable_d = stable_q;
    cand_d   = cand_q;
    active_d = active_q;
    count_d  = count_q;
    idle_d   = idle_q;
    sleep_d  = sleep_q;
    report   = 1'b0;
    unique case (mode_i)
      MODE_WAKE: begin
        sleep_d = 1'b0;
        idle_d  = '0;
      end
      MODE_SAMPLE: begin
        if (!sleep_q) begin
          // Debounce step.
          if (active_q) begin
            if (all_eq_cand) begin
              if (count_q < thr) begin
                count_d = count_inc;
                if (count_inc == thr) begin
                  stable_d = cand_q;
                  report   = 1'b1;
                end
              end
            end else begin
              active_d = 1'b0;
            end
          end else if (!all_eq_stable) begin
            cand_d   = sample_i;
            active_d = 1'b1;
            count_d  = '0;
          end
          // Idle step: a run of released samples past the limit sleeps.
          if (all_released) begin
            if (idle_q <= limit_ext) begin
              idle_d = idle_inc;
            end
            if (idle_d > limit_ext) begin
              sleep_d = 1'b1;
            end
          end else begin
            idle_d = '0;
          end
        end
      end
      MODE_RESEND: begin
        report = !sleep_q;
      end
      default: begin
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= '0;
      cand_q   <= '0;
      active_q <= 1'b0;
      count_q  <= '0;
      idle_q   <= '0;
      sleep_q  <= 1'b0;
    end else if (accept_i) begin
      stable_q <= stable_d;
      cand_q   <= cand_d;
      active_q <= active_d;
      count_q  <= count_d;
      idle_q   <= idle_d;
      sleep_q  <= sleep_d;
    end
  end

  assign stable_o        = stable_q;
  assign cand_o          = cand_q;
  assign result_o.report = report;
  assign result_o.keys   = stable_d;
  assign result_o.asleep = sleep_d;

endmodule

`default_nettype wire

@@ sv/key_matrix_debounce_idle_sleep.sv @@
// Channel       | Direction | Signals                      | Contents
// s_axis        | in        | tvalid tready tdata tuser    | key_matrix in tdata, mode in tuser
// m_axis        | out       | tvalid tready tdata tuser    | report_keys in tdata,
//               |           |                              | report_valid and asleep in tuser
// cfg           | in        | cfg_valid_i cfg_ready_o      | register index and write data
//
// One request is accepted per clock unless the output stalls; its result appears in the
// output register in the next cycle. The whole update (per-column compares, merge, state
// write) is combinational, which sets the rate of one request per clock.
// Reset clears the key state and loads the thresholds with 5 and 500.
// A result that is not taken holds the output register; a new request is then taken
// only in the cycle in which the waiting result leaves.
`default_nettype none

module key_matrix_debounce_idle_sleep (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // Input stream.
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // [44:0] key_matrix, rest zero
  input  wire [kmd_pkg::TDATA_W-1:0]     s_axis_tdata,
  // [1:0] mode
  input  wire [kmd_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  // Output stream.
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // [44:0] report_keys, rest zero
  output logic [kmd_pkg::TDATA_W-1:0]    m_axis_tdata,
  // [0] report_valid, [1] asleep
  output logic [kmd_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  // Configuration writes.
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [kmd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [kmd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import kmd_pkg::*;

  logic [THR_W-1:0]   thr_q;
  logic [LIMIT_W-1:0] limit_q;

  logic        accept;
  mode_e       mode;
  keys_t       key_in;
  keys_t       sample;
  keys_t       stable;
  keys_t       cand;
  lane_flags_t lane_flags [LANES];
  result_t     result;

  logic        out_valid_q;
  result_t     out_res_q;

  // Configuration registers are always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THR_RESET;
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_STABLE_TICKS: thr_q   <= cfg_wdata_i[THR_W-1:0];
        CFG_IDLE_LIMIT:   limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A request enters when the output register is free or empties this cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign mode          = mode_e'(s_axis_tuser);
  assign key_in        = s_axis_tdata[KEY_BITS-1:0];

  // One lane per column.
  for (genvar c = 0; c < int'(LANES); c++) begin : g_lane
    kmd_lane u_lane (
      .sample_i (key_in[c*ROW_STRIDE +: ROW_STRIDE]),
      .cand_i   (cand[c*ROW_STRIDE +: ROW_STRIDE]),
      .stable_i (stable[c*ROW_STRIDE +: ROW_STRIDE]),
      .sample_o (sample[c*ROW_STRIDE +: ROW_STRIDE]),
      .flags_o  (lane_flags[c])
    );
  end

  // Bits beyond the last column are never keys.
  if (USED_BITS < KEY_BITS) begin : g_pad
    assign sample[KEY_BITS-1:USED_BITS] = '0;
  end

  kmd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .mode_i       (mode),
    .sample_i     (sample),
    .lane_flags_i (lane_flags),
    .thr_cfg_i    (thr_q),
    .limit_cfg_i  (limit_q),
    .stable_o     (stable),
    .cand_o       (cand),
    .result_o     (result)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(TDATA_W - KEY_BITS){1'b0}}, out_res_q.keys};
  assign m_axis_tuser  = {out_res_q.asleep, out_res_q.report};

endmodule

`default_nettype wire
